// ===== rtl/pfl_pkg.sv =====
// Shared types and constants of the per-CPU free list block.
// Used by pfl_ctrl, pfl_datapath and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package pfl_pkg;

  // Fixed field widths of the command and result beats.
  localparam int NODE_W = 10;
  localparam int CPU_W  = 3;
  localparam int MASK_W = 8;

  // Command action codes.
  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_POP  = 1'b1;

  // One command beat.
  typedef struct packed {
    logic              action;
    logic [CPU_W-1:0]  cpu;
    logic [NODE_W-1:0] node;
  } cmd_t;

  // One result beat.
  typedef struct packed {
    logic              found;
    logic [NODE_W-1:0] node_out;
    logic [CPU_W-1:0]  served_cpu;
  } res_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic push;        // link the command's node onto its CPU's list
    logic pop_launch;  // search the lists and start the link read
    logic pop_finish;  // take the link read and update the head
  } ctrl_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/pfl_ctrl.sv =====
// Controller of the per-CPU free list block: accepts command beats and
// sequences pops through the ST_POP state. Depends on pfl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pfl_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  input  wire logic               action_i,
  output logic                    busy,
  output pfl_pkg::ctrl_cmd_t      cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_POP  = 1'b1;

  logic state_q, state_d;
  logic accept;

  // A beat is taken whenever no pop is finishing.
  assign busy   = (state_q == ST_POP);
  assign accept = start && !busy;

  assign cmd_o.push       = accept && (action_i == pfl_pkg::ACT_PUSH);
  assign cmd_o.pop_launch = accept && (action_i == pfl_pkg::ACT_POP);
  assign cmd_o.pop_finish = (state_q == ST_POP);

  // A pop passes through ST_POP while it waits on the link memory.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_o.pop_launch) begin
          state_d = ST_POP;
        end
      end
      ST_POP: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pfl_datapath.sv =====
// Datapath of the per-CPU free list block: head registers, the shared
// next-link memory, the stealing search and the result registers. Depends on pfl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pfl_datapath #(
  parameter int NUM_CPUS  = 8,
  parameter int NUM_NODES = 1024
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire pfl_pkg::ctrl_cmd_t          cmd_i,
  input  wire pfl_pkg::cmd_t               beat_i,
  input  wire logic                        cfg_we_i,
  input  wire logic [pfl_pkg::MASK_W-1:0]  cfg_wdata_i,
  output pfl_pkg::res_t                    result_o
);

  // Only the first eight CPUs can be named by a command.
  localparam int HN = (NUM_CPUS < pfl_pkg::MASK_W) ? NUM_CPUS : pfl_pkg::MASK_W;
  localparam int CW = (HN > 1) ? $clog2(HN) : 1;
  localparam int AW = $clog2(NUM_NODES);
  localparam int NW = (AW > pfl_pkg::NODE_W) ? AW : pfl_pkg::NODE_W;

  logic [pfl_pkg::MASK_W-1:0] possible_q;
  logic [pfl_pkg::NODE_W-1:0] head_node_q [HN];
  logic [HN-1:0]              head_vld_q;

  // Link memory entry: valid flag above the next node index.
  logic [pfl_pkg::NODE_W:0]   link_mem [NUM_NODES];
  logic [pfl_pkg::NODE_W:0]   link_rd_q;

  logic                       hit_q;
  logic [CW-1:0]              sel_q;
  logic [pfl_pkg::NODE_W-1:0] node_q;

  logic                       cpu_ok;
  logic                       node_ok;
  logic [CW-1:0]              own;
  logic [NW-1:0]              push_ext;
  logic [AW-1:0]              push_addr;
  logic [HN-1:0]              avail;
  logic                       sel_found;
  logic [CW-1:0]              sel;
  logic [pfl_pkg::NODE_W-1:0] sel_node;
  logic [NW-1:0]              pop_ext;
  logic [AW-1:0]              pop_addr;

  // Range checks and index forms of the command fields.
  assign cpu_ok    = (int'(beat_i.cpu) < NUM_CPUS);
  assign node_ok   = (int'(beat_i.node) < NUM_NODES);
  assign own       = beat_i.cpu[CW-1:0];
  assign push_ext  = NW'(beat_i.node);
  assign push_addr = push_ext[AW-1:0];

  // Lists a pop may take from: its own, CPU 0, and possible CPUs.
  always_comb begin
    for (int k = 0; k < HN; k++) begin
      avail[k] = head_vld_q[k] &&
                 (possible_q[k] || (k == int'(own)) || (k == 0));
    end
  end

  // Circular search for the first available list, starting at the requesting CPU.
  always_comb begin
    int            idx;
    logic [CW-1:0] pos;
    idx       = 0;
    pos       = '0;
    sel_found = 1'b0;
    sel       = '0;
    for (int i = 0; i < HN; i++) begin
      idx = int'(own) + i;
      if (idx >= HN) begin
        idx = idx - HN;
      end
      pos = CW'(idx);
      if (!sel_found && avail[pos]) begin
        sel_found = 1'b1;
        sel       = pos;
      end
    end
  end

  assign sel_node = head_node_q[sel];
  assign pop_ext  = NW'(sel_node);
  assign pop_addr = pop_ext[AW-1:0];

  // Mask of possible CPUs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      possible_q <= '1;
    end else if (cfg_we_i) begin
      possible_q <= cfg_wdata_i;
    end
  end

  // Head valid flags: set by a push, reloaded from the link on a pop.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_vld_q <= '0;
      hit_q      <= 1'b0;
    end else begin
      if (cmd_i.push && cpu_ok && node_ok) begin
        head_vld_q[own] <= 1'b1;
      end
      if (cmd_i.pop_finish && hit_q) begin
        head_vld_q[sel_q] <= link_rd_q[pfl_pkg::NODE_W];
      end
      if (cmd_i.pop_launch) begin
        hit_q <= cpu_ok && sel_found;
      end
    end
  end

  // Head node indices and the captured pop target.
  always_ff @(posedge clk_i) begin
    if (cmd_i.push && cpu_ok && node_ok) begin
      head_node_q[own] <= beat_i.node;
    end
    if (cmd_i.pop_finish && hit_q) begin
      head_node_q[sel_q] <= link_rd_q[pfl_pkg::NODE_W-1:0];
    end
    if (cmd_i.pop_launch) begin
      sel_q  <= sel;
      node_q <= sel_node;
    end
  end

  // Next-link memory: written by a push, read when a pop launches.
  always_ff @(posedge clk_i) begin
    if (cmd_i.push && cpu_ok && node_ok) begin
      link_mem[push_addr] <= {head_vld_q[own], head_node_q[own]};
    end
    if (cmd_i.pop_launch) begin
      link_rd_q <= link_mem[pop_addr];
    end
  end

  // Result beat; a miss reports zero node and CPU.
  assign result_o.found      = hit_q;
  assign result_o.node_out   = hit_q ? node_q : '0;
  assign result_o.served_cpu = hit_q ? pfl_pkg::CPU_W'(sel_q) : '0;

endmodule

`default_nettype wire

// ===== rtl/per_cpu_free_list_stealing_unit.sv =====
// Top level of the per-CPU free list block with work stealing.
// Instantiates pfl_ctrl and pfl_datapath; depends on pfl_pkg.
//
// Usage:
//   A command beat on cmd_i is taken at a rising edge with start high and
//   busy low. A push links cmd_i.node onto the list of cmd_i.cpu in that
//   cycle and gives no result; busy stays low, so a new beat may follow in
//   the next cycle. A pop searches the lists at acceptance, starting at its
//   own CPU and stealing from the next list in ascending, wrapping order,
//   and starts a read of the next-link memory. The result beat appears on
//   result_o in the following cycle, marked by result_valid_o for exactly
//   one cycle, while busy is high. A pop waits on the registered read of the
//   link memory. The receiver cannot stall results. The user must write the
//   possible-CPU mask through cfg_we_i and cfg_wdata_i only while no pop is
//   in progress; the block does not enforce this. Reset empties all lists
//   and sets the mask to all ones; the link memory needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module per_cpu_free_list_stealing_unit #(
  parameter int NUM_CPUS  = 8,
  parameter int NUM_NODES = 1024
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire pfl_pkg::cmd_t               cmd_i,
  output logic                             result_valid_o,
  output pfl_pkg::res_t                    result_o,
  input  wire logic                        cfg_we_i,
  input  wire logic [pfl_pkg::MASK_W-1:0]  cfg_wdata_i
);

  pfl_pkg::ctrl_cmd_t ctrl_cmd;

  // Command acceptance and pop sequencing.
  pfl_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .action_i (cmd_i.action),
    .busy     (busy),
    .cmd_o    (ctrl_cmd)
  );

  // Lists, link memory and result registers.
  pfl_datapath #(
    .NUM_CPUS  (NUM_CPUS),
    .NUM_NODES (NUM_NODES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (ctrl_cmd),
    .beat_i      (cmd_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .result_o    (result_o)
  );

  assign result_valid_o = ctrl_cmd.pop_finish;

endmodule

`default_nettype wire
